>>> hdl/lfsc_pkg.sv
// shared constants and types for the lru frame slot cache
`default_nettype none

package lfsc_pkg;

	// default number of cache slots
	localparam int unsigned CACHE_SLOTS_DEF = 16;

	// payload widths
	localparam int unsigned FRAME_W     = 32;
	localparam int unsigned SLOT_W      = 4;
	localparam int unsigned OUT_TDATA_W = 40;
	localparam int unsigned OUT_TUSER_W = 2;

	// bit positions inside the result tuser
	localparam int unsigned TUSER_HIT     = 0;
	localparam int unsigned TUSER_EVICTED = 1;

	// update strobe shared by the tag store and the recency tracker
	typedef struct packed {
		logic fire;
		logic hit;
	} lfsc_upd_t;

endpackage

`default_nettype wire

>>> hdl/lfsc_tags.sv
// tag store with parallel compare and victim tag readout
`default_nettype none

module lfsc_tags #(
	parameter int unsigned CACHE_SLOTS = lfsc_pkg::CACHE_SLOTS_DEF
) (
	input  wire                             clk,
	input  wire lfsc_pkg::lfsc_upd_t        upd,
	input  wire [lfsc_pkg::FRAME_W-1:0]     frame,
	input  wire [CACHE_SLOTS-1:0]           filled,
	input  wire [$clog2(CACHE_SLOTS)-1:0]   wr_slot,
	input  wire [$clog2(CACHE_SLOTS)-1:0]   victim,
	output logic [CACHE_SLOTS-1:0]          match,
	output logic [lfsc_pkg::FRAME_W-1:0]    victim_tag
);
	import lfsc_pkg::*;

	logic [FRAME_W-1:0] tag_q [CACHE_SLOTS];

	// tag write on every miss, either a free slot or the victim slot
	always_ff @(posedge clk) begin
		if (upd.fire && !upd.hit) begin
			tag_q[wr_slot] <= frame;
		end
	end

	// compare against every filled slot at once
	always_comb begin
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			match[i] = filled[i] && (tag_q[i] == frame);
		end
	end

	// frame held by the least recently used slot
	assign victim_tag = tag_q[victim];

endmodule

`default_nettype wire

>>> hdl/lfsc_lru.sv
// recency ranks per slot, fill count and victim search
`default_nettype none

module lfsc_lru #(
	parameter int unsigned CACHE_SLOTS = lfsc_pkg::CACHE_SLOTS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire lfsc_pkg::lfsc_upd_t        upd,
	input  wire [$clog2(CACHE_SLOTS)-1:0]   slot,
	output logic [CACHE_SLOTS-1:0]          filled,
	output logic                            full,
	output logic [$clog2(CACHE_SLOTS)-1:0]  victim,
	output logic [$clog2(CACHE_SLOTS)-1:0]  fill_idx
);
	import lfsc_pkg::*;

	localparam int unsigned IDX_W  = $clog2(CACHE_SLOTS);
	localparam int unsigned FILL_W = $clog2(CACHE_SLOTS + 1);

	// rank 0 is least recently used, fill_q-1 most recently used
	logic [IDX_W-1:0]       rank_q [CACHE_SLOTS];
	logic [FILL_W-1:0]      fill_q;
	logic [CACHE_SLOTS-1:0] victim_vec;
	logic [IDX_W-1:0]       acc_rank;
	logic [IDX_W-1:0]       top_rank;

	assign full     = (fill_q == FILL_W'(CACHE_SLOTS));
	assign fill_idx = IDX_W'(fill_q);
	assign acc_rank = rank_q[slot];
	assign top_rank = IDX_W'(fill_q - FILL_W'(1));

	// occupancy mask from the fill count
	always_comb begin
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			filled[i] = (FILL_W'(i) < fill_q);
		end
	end

	// victim is the filled slot with rank zero
	always_comb begin
		victim = '0;
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			victim_vec[i] = filled[i] && (rank_q[i] == '0);
			if (victim_vec[i]) begin
				victim = IDX_W'(i);
			end
		end
	end

	// rank update: hit/evict puts the slot on top, younger slots move down one; a fill gets rank fill_q
	always_ff @(posedge clk) begin
		if (upd.fire) begin
			if (upd.hit || full) begin
				for (int i = 0; i < CACHE_SLOTS; i++) begin
					if (IDX_W'(i) == slot) begin
						rank_q[i] <= top_rank;
					end else if (filled[i] && (rank_q[i] > acc_rank)) begin
						rank_q[i] <= rank_q[i] - IDX_W'(1);
					end
				end
			end else begin
				rank_q[slot] <= IDX_W'(fill_q);
			end
		end
	end

	// fill count grows on each miss until all slots are used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (upd.fire && !upd.hit && !full) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CACHE_SLOTS))
		else $error("fill count beyond slot count");

	a_one_victim: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> $onehot(victim_vec))
		else $error("ranks do not hold exactly one lru slot");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		upd.fire && !upd.hit && !full |=> fill_q == $past(fill_q) + FILL_W'(1))
		else $error("miss on free slot did not advance fill count");

endmodule

`default_nettype wire

>>> hdl/lru_frame_slot_cache_core.sv
// Fully associative frame slot cache directory with true LRU replacement.
// Input channel s_*: one item per request, s_tdata carries the 32-bit frame
// number. Output channel m_*: one result item per request, with the slot
// that holds or now receives the frame, the hit and eviction flags in
// m_tuser, and the evicted frame number (zero unless a frame was evicted).
// Structure: the request is captured in an input register, the tag compare,
// victim search and rank update are computed combinationally from there, and the
// result lands in an output register while tags, ranks and fill count update
// on the same edge.
// Throughput: one item per cycle unless m_tready stalls; the next request
// reads the state that the previous one writes as its result is registered.
// Reset: the fill count and both valid flags clear; tags and ranks are only
// read for slots below the fill count, so they need no clearing pass.
// Stall: while m_tready is low and a result waits, the input register holds
// its item and s_tready drops once that register is occupied.
`default_nettype none

module lru_frame_slot_cache_core #(
	parameter int unsigned CACHE_SLOTS = lfsc_pkg::CACHE_SLOTS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [lfsc_pkg::FRAME_W-1:0]        s_tdata,   // [31:0] frame_number
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [lfsc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [3:0] slot, [35:4] evicted_frame
	output logic [lfsc_pkg::OUT_TUSER_W-1:0]   m_tuser    // [0] hit, [1] evicted
);
	import lfsc_pkg::*;

	localparam int unsigned IDX_W = $clog2(CACHE_SLOTS);

	logic               valid_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic               out_valid_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               evicted_q;
	logic [FRAME_W-1:0] evicted_frame_q;

	logic                   advance;
	logic                   fire;
	logic                   hit;
	logic                   full;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       victim;
	logic [IDX_W-1:0]       fill_idx;
	logic [IDX_W-1:0]       slot;
	logic [CACHE_SLOTS-1:0] filled;
	logic [CACHE_SLOTS-1:0] match;
	logic [FRAME_W-1:0]     victim_tag;
	lfsc_upd_t              upd;

	// handshake: the input register moves whenever the output register frees
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			frame_s1 <= s_tdata;
		end
	end

	// hit slot encode
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign hit = |match;

	// slot choice: hit slot, else next free slot, else lru victim
	assign slot = hit ? hit_idx : (full ? victim : fill_idx);

	assign upd.fire = fire;
	assign upd.hit  = hit;

	lfsc_tags #(
		.CACHE_SLOTS(CACHE_SLOTS)
	) u_tags (
		.clk        (clk),
		.upd        (upd),
		.frame      (frame_s1),
		.filled     (filled),
		.wr_slot    (slot),
		.victim     (victim),
		.match      (match),
		.victim_tag (victim_tag)
	);

	lfsc_lru #(
		.CACHE_SLOTS(CACHE_SLOTS)
	) u_lru (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.slot     (slot),
		.filled   (filled),
		.full     (full),
		.victim   (victim),
		.fill_idx (fill_idx)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q           <= hit;
			slot_q          <= SLOT_W'(slot);
			evicted_q       <= !hit && full;
			evicted_frame_q <= (!hit && full) ? victim_tag : '0;
		end
	end

	assign m_tvalid                = out_valid_q;
	assign m_tdata                 = OUT_TDATA_W'({evicted_frame_q, slot_q});
	assign m_tuser[TUSER_HIT]      = hit_q;
	assign m_tuser[TUSER_EVICTED]  = evicted_q;

	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		fire && hit |-> $onehot(match))
		else $error("frame found in more than one slot");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evicted_q |-> !hit_q)
		else $error("eviction reported on a hit");

	a_hit_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fire && hit |=> out_valid_q && hit_q && !evicted_q && evicted_frame_q == '0)
		else $error("hit result carries eviction data");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// self-checking testbench for the lru frame slot cache directory
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lfsc_pkg::*;

	localparam int unsigned NUM_SLOTS    = CACHE_SLOTS_DEF;
	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned RECENT_DEPTH = 20;
	localparam int unsigned DIR_DEPTH    = 32;
	localparam int unsigned PEND_DEPTH   = 16;

	// one lookup result as the block reports it
	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               evicted;
		logic [FRAME_W-1:0] evicted_frame;
	} lookup_res_t;

	// one row of the directed stimulus
	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               known;
		lookup_res_t        res;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [FRAME_W-1:0]     s_tdata = '0;      // [31:0] frame_number
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;           // [3:0] slot, [35:4] evicted_frame
	logic [OUT_TUSER_W-1:0] m_tuser;           // [0] hit, [1] evicted

	// predicted directory state
	logic [FRAME_W-1:0] slot_frame [NUM_SLOTS];
	int unsigned        lru_list [NUM_SLOTS];
	int unsigned        slots_used = 0;

	// expected results in order, written by the sender, read by the checker
	lookup_res_t        pending_res [PEND_DEPTH];
	int unsigned        pend_wr = 0;
	int unsigned        pend_rd = 0;

	dir_row_t           dir_rows [DIR_DEPTH];
	int unsigned        dir_count = 0;

	// ring of recently sent frames
	logic [FRAME_W-1:0] recent_frames [RECENT_DEPTH];
	int unsigned        recent_cnt = 0;
	int unsigned        recent_wr = 0;

	int unsigned send_idle_pct = 36;
	int unsigned recv_idle_pct = 87;
	int unsigned hold_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_cnt = 0;

	lru_frame_slot_cache_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[lru_frame_slot_cache_core] ERROR");
			$finish;
		end
	end

	// results still expected
	function automatic int unsigned pend_count();
		return pend_wr - pend_rd;
	endfunction

	// move the order entry at pos to the most recently used end
	function automatic void make_mru(input int unsigned pos);
		int unsigned s;
		s = lru_list[pos];
		for (int unsigned i = pos; i + 1 < slots_used; i++)
			lru_list[i] = lru_list[i + 1];
		lru_list[slots_used - 1] = s;
	endfunction

	// look up one frame and update the predicted directory
	function automatic lookup_res_t cache_lookup(input logic [FRAME_W-1:0] frame);
		lookup_res_t r;
		int unsigned s;
		r = '0;
		// search the filled slots
		for (int unsigned pos = 0; pos < slots_used; pos++) begin
			s = lru_list[pos];
			if (slot_frame[s] == frame) begin
				make_mru(pos);
				r.hit = 1'b1;
				r.slot = s[SLOT_W-1:0];
				return r;
			end
		end
		// fill a free slot
		if (slots_used < NUM_SLOTS) begin
			s = slots_used;
			slot_frame[s] = frame;
			lru_list[s] = s;
			slots_used++;
			r.slot = s[SLOT_W-1:0];
			return r;
		end
		// evict the least recently used frame
		s = lru_list[0];
		r.slot = s[SLOT_W-1:0];
		r.evicted = 1'b1;
		r.evicted_frame = slot_frame[s];
		make_mru(0);
		slot_frame[s] = frame;
		return r;
	endfunction

	task automatic add_row(input logic [FRAME_W-1:0] frame, input logic known,
			input logic hit, input int unsigned slot, input logic evicted,
			input logic [FRAME_W-1:0] evicted_frame);
		dir_row_t row;
		row.frame = frame;
		row.known = known;
		row.res.hit = hit;
		row.res.slot = slot[SLOT_W-1:0];
		row.res.evicted = evicted;
		row.res.evicted_frame = evicted_frame;
		dir_rows[dir_count] = row;
		dir_count++;
	endtask

	// offer one item, then queue its expected result once accepted
	task automatic send_item(input logic [FRAME_W-1:0] frame, input logic known,
			input lookup_res_t typed);
		lookup_res_t pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= frame;
		do @(posedge clk); while (!s_tready);
		pred = cache_lookup(frame);
		pending_res[pend_wr % PEND_DEPTH] = known ? typed : pred;
		pend_wr++;
		recent_frames[recent_wr] = frame;
		recent_wr = (recent_wr + 1) % RECENT_DEPTH;
		if (recent_cnt < RECENT_DEPTH)
			recent_cnt++;
	endtask

	// pick a random request, biased toward reuse so hits and evictions both occur
	function automatic logic [FRAME_W-1:0] pick_frame();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35 && recent_cnt > 0)
			return recent_frames[$urandom_range(0, recent_cnt - 1)];
		if (r < 60)
			return FRAME_W'($urandom_range(0, 23));
		if (r < 70 && recent_cnt > 0)
			return recent_frames[(recent_wr + RECENT_DEPTH - 1) % RECENT_DEPTH];
		if (r < 80) begin
			case ($urandom_range(0, 4))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h8000_0000;
				3: return 32'h7FFF_FFFF;
				default: return 32'hFFFF_FFFE;
			endcase
		end
		return FRAME_W'($urandom());
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pend_count() != 0)
			@(posedge clk);
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	// receiver: random ready, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		lookup_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pend_count() == 0) begin
				note_mismatch($sformatf("result with nothing pending, tdata %h tuser %b",
					m_tdata, m_tuser));
			end else begin
				want = pending_res[pend_rd % PEND_DEPTH];
				pend_rd++;
				if (m_tuser[TUSER_HIT] !== want.hit)
					note_mismatch($sformatf("hit expected %b got %b",
						want.hit, m_tuser[TUSER_HIT]));
				if (m_tdata[SLOT_W-1:0] !== want.slot)
					note_mismatch($sformatf("slot expected %0d got %0d",
						want.slot, m_tdata[SLOT_W-1:0]));
				if (m_tuser[TUSER_EVICTED] !== want.evicted)
					note_mismatch($sformatf("evicted expected %b got %b",
						want.evicted, m_tuser[TUSER_EVICTED]));
				if (m_tdata[SLOT_W +: FRAME_W] !== want.evicted_frame)
					note_mismatch($sformatf("evicted_frame expected %h got %h",
						want.evicted_frame, m_tdata[SLOT_W +: FRAME_W]));
				if (m_tdata[OUT_TDATA_W-1:SLOT_W+FRAME_W] !== '0)
					note_mismatch($sformatf("tdata padding expected 0 got %h",
						m_tdata[OUT_TDATA_W-1:SLOT_W+FRAME_W]));
			end
		end
	end

	// stimulus
	initial begin
		// directed rows: first fills, hits, repeated hit, eviction of extreme frames
		add_row(32'h0000_0000, 1'b1, 1'b0, 0, 1'b0, 32'h0);
		add_row(32'hFFFF_FFFF, 1'b1, 1'b0, 1, 1'b0, 32'h0);
		add_row(32'h0000_0000, 1'b1, 1'b1, 0, 1'b0, 32'h0);
		add_row(32'h0000_0000, 1'b1, 1'b1, 0, 1'b0, 32'h0);
		add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1'b0, 32'h0);
		add_row(32'h8000_0000, 1'b1, 1'b0, 2, 1'b0, 32'h0);
		add_row(32'h7FFF_FFFF, 1'b1, 1'b0, 3, 1'b0, 32'h0);
		add_row(32'h5555_5555, 1'b0, 1'b0, 0, 1'b0, 32'h0);
		add_row(32'hAAAA_AAAA, 1'b0, 1'b0, 0, 1'b0, 32'h0);
		for (int unsigned i = 0; i < 10; i++)
			add_row(32'h0000_1000 + i, 1'b0, 1'b0, 0, 1'b0, 32'h0);
		// directory full: oldest frames go first
		add_row(32'hDEAD_BEEF, 1'b1, 1'b0, 0, 1'b1, 32'h0000_0000);
		add_row(32'h1234_5678, 1'b1, 1'b0, 1, 1'b1, 32'hFFFF_FFFF);
		add_row(32'hDEAD_BEEF, 1'b1, 1'b1, 0, 1'b0, 32'h0);
		add_row(32'h0000_0000, 1'b1, 1'b0, 2, 1'b1, 32'h8000_0000);
		add_row(32'h0000_0000, 1'b1, 1'b1, 2, 1'b0, 32'h0);

		// reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < dir_count; i++)
			send_item(dir_rows[i].frame, dir_rows[i].known, dir_rows[i].res);

		// random requests in three idling phases
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 240) begin
				wait_drained();
				send_idle_pct = 87;
				recv_idle_pct = 36;
			end else if (n == 480) begin
				wait_drained();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_cycles = 120;
			end
			send_item(pick_frame(), 1'b0, '0);
		end

		// drain and report
		recv_idle_pct = 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pend_count() == 0) begin
			$display("[lru_frame_slot_cache_core] OK");
		end else begin
			$display("[lru_frame_slot_cache_core] ERROR");
		end
		$finish;
	end

endmodule
